// File: sv/hrhs_pkg.sv
// Shared types, codes and constants of the HTTP request head scanner.
// No dependencies; every other file of the block but hrhs_if.sv refers to this package.
`timescale 1ns / 1ps

package hrhs_pkg;

  localparam int COUNT_BITS_DEF = 16;
  localparam int NUM_WORDS      = 7;
  localparam int QUEUE_DEPTH    = 2;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 16;

  localparam logic [15:0] MAX_HEAD_RST  = 16'd4096;
  localparam logic [7:0]  MIN_HEAD_RST  = 8'd8;
  localparam logic [7:0]  MIN_MOUNT_RST = 8'd5;
  localparam logic [7:0]  MAX_MOUNT_RST = 8'd127;

  localparam logic [7:0] MOUNT_SAT = 8'hFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MAX_HEAD  = 2'd0,
    REG_MIN_HEAD  = 2'd1,
    REG_MIN_MOUNT = 2'd2,
    REG_MAX_MOUNT = 2'd3
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_SHORT     = 3'd1,
    ST_UNKNOWN   = 3'd2,
    ST_BAD_MOUNT = 3'd3,
    ST_OVERFLOW  = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    METH_NONE    = 3'd0,
    METH_GET     = 3'd1,
    METH_PUT     = 3'd2,
    METH_HEAD    = 3'd3,
    METH_SOURCE  = 3'd4,
    METH_POST    = 3'd5,
    METH_PATCH   = 3'd6,
    METH_OPTIONS = 3'd7
  } method_t;

  typedef enum logic {
    EVT_END      = 1'b0,
    EVT_OVERFLOW = 1'b1
  } evt_kind_t;

  // Method words, space padded to eight characters; bytes past a word's
  // length are never compared.
  localparam logic [63:0] WORD_TEXT [NUM_WORDS] = '{
    "GET     ", "PUT     ", "HEAD    ", "SOURCE  ",
    "POST    ", "PATCH   ", "OPTIONS "
  };
  localparam logic [3:0] WORD_LEN [NUM_WORDS] = '{
    4'd4, 4'd4, 4'd5, 4'd7, 4'd5, 4'd6, 4'd8
  };
  // candidate bits of the two words followed by a mount path
  localparam int WORD_PUT    = 1;
  localparam int WORD_SOURCE = 3;

  typedef struct packed {
    logic [15:0] max_head_bytes;
    logic [7:0]  min_head_length;
    logic [7:0]  min_mount_length;
    logic [7:0]  max_mount_length;
  } hrhs_cfg_t;

  // One classified end-of-scan beat, front to back.
  typedef struct packed {
    evt_kind_t            kind;
    logic                 too_short;
    logic [NUM_WORDS-1:0] word_hit;   // candidate still matching and complete
    logic [15:0]          head_length;
    logic [7:0]           mount_length;
  } hrhs_evt_t;

  function automatic logic [7:0] word_char(input int k, input logic [2:0] pos);
    logic [63:0] w;
    w = WORD_TEXT[k];
    return w[63 - 8*pos -: 8];
  endfunction

endpackage

// File: sv/hrhs_if.sv
// Valid/ready channel interfaces of the head scanner: byte input, result
// output and configuration write. Depends on nothing.
`timescale 1ns / 1ps

interface hrhs_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;
  logic       new_request;
  modport source (output valid, byte_value, new_request, input ready);
  modport sink   (input valid, byte_value, new_request, output ready);
endinterface

interface hrhs_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [2:0]  method;
  logic [15:0] head_length;
  logic [7:0]  mount_length;
  modport source (output valid, status, method, head_length, mount_length, input ready);
  modport sink   (input valid, status, method, head_length, mount_length, output ready);
endinterface

interface hrhs_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: sv/hrhs_front.sv
// Front end of the head scanner: takes one byte a beat, tracks method
// match, mount path and CR/LF runs, and pushes an event at end or overflow.
// Depends on hrhs_pkg and hrhs_if.
`timescale 1ns / 1ps

module hrhs_front #(
  parameter int COUNT_BITS = hrhs_pkg::COUNT_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  hrhs_in_if.sink             in_ch,
  input  hrhs_pkg::hrhs_cfg_t cfg,
  input  logic                q_full,
  output logic                q_push,
  output hrhs_pkg::hrhs_evt_t q_data
);

  localparam int NW   = hrhs_pkg::NUM_WORDS;
  localparam int CMPW = (COUNT_BITS + 1 > 16) ? COUNT_BITS + 1 : 16;

  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_SP  = 8'h20;
  localparam logic [7:0] CH_AMP = 8'h26;
  localparam logic [7:0] CH_QM  = 8'h3F;
  localparam logic [7:0] CH_NUL = 8'h00;

  logic [COUNT_BITS-1:0] cnt_r,  cnt_nxt;
  logic [NW-1:0]         cand_r, cand_nxt;
  logic [COUNT_BITS-1:0] last_r, last_nxt;
  logic [1:0]            run_r,  run_nxt;
  logic [7:0]            mc_r,   mc_nxt;
  logic                  open_r, open_nxt;
  logic                  fin_r,  fin_nxt;

  logic                  accept;
  logic [7:0]            b;
  logic [COUNT_BITS-1:0] cnt_e, last_e;
  logic [NW-1:0]         cand_e;
  logic [1:0]            run_e;
  logic [7:0]            mc_e;
  logic                  open_e, fin_e;
  logic                  is_stop, is_eol;
  logic [CMPW-1:0]       next_idx;
  logic                  evt_valid;
  hrhs_pkg::hrhs_evt_t   evt;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign b           = in_ch.byte_value;

  always_comb begin
    // new_request clears the scan before this byte is looked at
    if (in_ch.new_request) begin
      cnt_e  = '0;
      cand_e = '1;
      last_e = '1;
      run_e  = '0;
      mc_e   = '0;
      open_e = 1'b0;
      fin_e  = 1'b0;
    end else begin
      cnt_e  = cnt_r;
      cand_e = cand_r;
      last_e = last_r;
      run_e  = run_r;
      mc_e   = mc_r;
      open_e = open_r;
      fin_e  = fin_r;
    end

    cnt_nxt  = cnt_e;
    cand_nxt = cand_e;
    last_nxt = last_e;
    run_nxt  = run_e;
    mc_nxt   = mc_e;
    open_nxt = open_e;
    fin_nxt  = fin_e;

    is_stop = (b == CH_SP) || (b == CH_AMP) || (b == CH_QM) ||
              (b == CH_LF) || (b == CH_CR) || (b == CH_NUL);
    is_eol  = (b == CH_LF) || (b == CH_CR);
    next_idx = CMPW'(cnt_e) + CMPW'(1);

    evt_valid         = 1'b0;
    evt.kind          = hrhs_pkg::EVT_END;
    evt.too_short     = 1'b0;
    evt.word_hit      = '0;
    evt.head_length   = 16'(cnt_e);
    evt.mount_length  = '0;

    if (!fin_e) begin
      if (open_e) begin
        if (is_stop) begin
          open_nxt = 1'b0;
        end else if (mc_e != hrhs_pkg::MOUNT_SAT) begin
          mc_nxt = mc_e + 8'd1;
        end
      end

      for (int k = 0; k < NW; k++) begin
        if (cnt_e < COUNT_BITS'(hrhs_pkg::WORD_LEN[k]) &&
            hrhs_pkg::word_char(k, cnt_e[2:0]) != b) begin
          cand_nxt[k] = 1'b0;
        end
      end
      // the mount path starts right after "PUT " or "SOURCE "
      if (cnt_e == COUNT_BITS'(3) && cand_nxt[hrhs_pkg::WORD_PUT]) begin
        open_nxt = 1'b1;
      end
      if (cnt_e == COUNT_BITS'(6) && cand_nxt[hrhs_pkg::WORD_SOURCE]) begin
        open_nxt = 1'b1;
      end

      if (is_eol) begin
        run_nxt = (last_e != cnt_e - COUNT_BITS'(1)) ? 2'd0 : run_e;
        last_nxt = cnt_e;
        if (b == CH_LF) begin
          run_nxt = run_nxt + 2'd1;
        end
      end

      if (is_eol && run_nxt == 2'd2) begin
        fin_nxt          = 1'b1;
        evt_valid        = 1'b1;
        evt.too_short    = cnt_e < COUNT_BITS'(cfg.min_head_length);
        evt.mount_length = mc_nxt;
        for (int k = 0; k < NW; k++) begin
          evt.word_hit[k] = cand_nxt[k] &&
                            (COUNT_BITS'(hrhs_pkg::WORD_LEN[k]) <= cnt_e);
        end
      end else if (next_idx >= CMPW'(cfg.max_head_bytes) || cnt_e == '1) begin
        fin_nxt         = 1'b1;
        evt_valid       = 1'b1;
        evt.kind        = hrhs_pkg::EVT_OVERFLOW;
        evt.head_length = '0;
      end else begin
        cnt_nxt = cnt_e + COUNT_BITS'(1);
      end
    end
  end

  assign q_push = accept && evt_valid;
  assign q_data = evt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      cand_r <= '1;
      last_r <= '1;
      run_r  <= '0;
      mc_r   <= '0;
      open_r <= 1'b0;
      fin_r  <= 1'b0;
    end else if (accept) begin
      cnt_r  <= cnt_nxt;
      cand_r <= cand_nxt;
      last_r <= last_nxt;
      run_r  <= run_nxt;
      mc_r   <= mc_nxt;
      open_r <= open_nxt;
      fin_r  <= fin_nxt;
    end
  end

endmodule

// File: sv/hrhs_queue.sv
// Short event queue between scanner front and result back end.
// Depends on hrhs_pkg.
`timescale 1ns / 1ps

module hrhs_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  hrhs_pkg::hrhs_evt_t push_data,
  input  logic                pop,
  output hrhs_pkg::hrhs_evt_t head,
  output logic                full,
  output logic                empty
);

  localparam int DEPTH = hrhs_pkg::QUEUE_DEPTH;
  localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  hrhs_pkg::hrhs_evt_t mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [PW:0]   fill_r,   fill_nxt;

  assign full  = (fill_r == (PW+1)'(DEPTH));
  assign empty = (fill_r == '0);
  assign head  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (push && !pop) begin
      fill_nxt = fill_r + (PW+1)'(1);
    end else if (pop && !push) begin
      fill_nxt = fill_r - (PW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

endmodule

// File: sv/hrhs_back.sv
// Back end of the head scanner: turns a queued event into the status,
// method and lengths of one result and holds it in the output register.
// Depends on hrhs_pkg and hrhs_if.
`timescale 1ns / 1ps

module hrhs_back (
  input  logic                clk,
  input  logic                rst_n,
  input  hrhs_pkg::hrhs_cfg_t cfg,
  input  logic                q_empty,
  input  hrhs_pkg::hrhs_evt_t q_head,
  output logic                q_pop,
  hrhs_out_if.source          out_ch
);

  logic                    vld_r;
  hrhs_pkg::status_t       status_r, status_nxt;
  hrhs_pkg::method_t       method_r, method_nxt;
  logic [15:0]             hlen_r,   hlen_nxt;
  logic [7:0]              mlen_r,   mlen_nxt;
  hrhs_pkg::method_t       hit;
  logic                    mount_bad;

  assign q_pop = !q_empty && (!vld_r || out_ch.ready);

  always_comb begin
    // lowest numbered word wins
    hit = hrhs_pkg::METH_NONE;
    for (int k = hrhs_pkg::NUM_WORDS - 1; k >= 0; k--) begin
      if (q_head.word_hit[k]) begin
        hit = hrhs_pkg::method_t'(3'(k + 1));
      end
    end

    mount_bad = (q_head.mount_length < cfg.min_mount_length) ||
                (q_head.mount_length > cfg.max_mount_length) ||
                (q_head.mount_length == hrhs_pkg::MOUNT_SAT);

    status_nxt = hrhs_pkg::ST_OK;
    method_nxt = hrhs_pkg::METH_NONE;
    hlen_nxt   = q_head.head_length;
    mlen_nxt   = '0;

    if (q_head.kind == hrhs_pkg::EVT_OVERFLOW) begin
      status_nxt = hrhs_pkg::ST_OVERFLOW;
      hlen_nxt   = '0;
    end else if (q_head.too_short) begin
      status_nxt = hrhs_pkg::ST_SHORT;
    end else if (hit == hrhs_pkg::METH_NONE) begin
      status_nxt = hrhs_pkg::ST_UNKNOWN;
    end else begin
      method_nxt = hit;
      if (hit == hrhs_pkg::METH_PUT || hit == hrhs_pkg::METH_SOURCE) begin
        mlen_nxt = q_head.mount_length;
        if (mount_bad) begin
          status_nxt = hrhs_pkg::ST_BAD_MOUNT;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (q_pop) begin
      vld_r <= 1'b1;
    end else if (out_ch.ready) begin
      vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      status_r <= status_nxt;
      method_r <= method_nxt;
      hlen_r   <= hlen_nxt;
      mlen_r   <= mlen_nxt;
    end
  end

  assign out_ch.valid        = vld_r;
  assign out_ch.status       = status_r;
  assign out_ch.method       = method_r;
  assign out_ch.head_length  = hlen_r;
  assign out_ch.mount_length = mlen_r;

endmodule

// File: sv/http_request_head_scanner_unit.sv
// HTTP request head scanner, top level: configuration registers, front end,
// event queue and back end. Depends on hrhs_pkg, hrhs_if and the hrhs_* modules.
// Takes one byte per cycle while the two-entry event queue has room; a result
// is queued with the byte ending the scan, then loaded into the output register.
// Reset (rst_n, synchronous, active low) loads the register defaults and
// clears scan state, queue and output valid.
`timescale 1ns / 1ps

module http_request_head_scanner_unit #(
  parameter int COUNT_BITS = hrhs_pkg::COUNT_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  hrhs_in_if.sink     in_ch,
  hrhs_out_if.source  out_ch,
  hrhs_cfg_if.sink    cfg_ch
);

  hrhs_pkg::hrhs_cfg_t cfg_r, cfg_nxt;
  logic                q_push, q_pop, q_full, q_empty;
  hrhs_pkg::hrhs_evt_t q_wdata, q_head;

  assign cfg_ch.ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_ch.valid) begin
      case (hrhs_pkg::cfg_reg_t'(cfg_ch.index))
        hrhs_pkg::REG_MAX_HEAD:  cfg_nxt.max_head_bytes   = cfg_ch.data;
        hrhs_pkg::REG_MIN_HEAD:  cfg_nxt.min_head_length  = cfg_ch.data[7:0];
        hrhs_pkg::REG_MIN_MOUNT: cfg_nxt.min_mount_length = cfg_ch.data[7:0];
        hrhs_pkg::REG_MAX_MOUNT: cfg_nxt.max_mount_length = cfg_ch.data[7:0];
        default:                 cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_head_bytes   <= hrhs_pkg::MAX_HEAD_RST;
      cfg_r.min_head_length  <= hrhs_pkg::MIN_HEAD_RST;
      cfg_r.min_mount_length <= hrhs_pkg::MIN_MOUNT_RST;
      cfg_r.max_mount_length <= hrhs_pkg::MAX_MOUNT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  hrhs_front #(
    .COUNT_BITS (COUNT_BITS)
  ) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .cfg    (cfg_r),
    .q_full (q_full),
    .q_push (q_push),
    .q_data (q_wdata)
  );

  hrhs_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .pop       (q_pop),
    .head      (q_head),
    .full      (q_full),
    .empty     (q_empty)
  );

  hrhs_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .q_empty (q_empty),
    .q_head  (q_head),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule

// File: verif/tb_top.sv
// Testbench for http_request_head_scanner_unit: random and directed request streams,
// a cycle-free scoreboard of the head scanner and per-field result checks.
// Depends on hrhs_pkg, the hrhs_if channel interfaces and the scanner RTL.
`timescale 1ns / 1ps

module tb_top;

  localparam int NUM_METHODS = hrhs_pkg::NUM_WORDS;
  localparam int CAND_PUT    = hrhs_pkg::WORD_PUT;
  localparam int CAND_SOURCE = hrhs_pkg::WORD_SOURCE;

  localparam logic [7:0] CHAR_NUL = 8'h00;
  localparam logic [7:0] CHAR_LF  = 8'h0A;
  localparam logic [7:0] CHAR_CR  = 8'h0D;
  localparam logic [7:0] CHAR_SP  = 8'h20;
  localparam logic [7:0] CHAR_AMP = 8'h26;
  localparam logic [7:0] CHAR_QM  = 8'h3F;

  typedef struct packed {
    hrhs_pkg::status_t status;
    hrhs_pkg::method_t method;
    logic [15:0]       head_length;
    logic [7:0]        mount_length;
  } head_result_t;

  string method_word [NUM_METHODS] = '{
    "GET ", "PUT ", "HEAD ", "SOURCE ", "POST ", "PATCH ", "OPTIONS "
  };
  logic [7:0] stop_chars [6] = '{CHAR_SP, CHAR_AMP, CHAR_QM, CHAR_CR, CHAR_LF, CHAR_NUL};

  logic clk = 1'b0;
  logic rst_n;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  hrhs_in_if  in_ch ();
  hrhs_out_if out_ch ();
  hrhs_cfg_if cfg_ch ();

  http_request_head_scanner_unit i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // scanner limits as last written
  logic [15:0] lim_max_head;
  logic [7:0]  lim_min_head;
  logic [7:0]  lim_min_mount;
  logic [7:0]  lim_max_mount;

  // scan state of the current request
  logic [15:0] scan_count;
  logic [6:0]  scan_cands;
  logic [15:0] scan_last_eol;
  logic [1:0]  scan_lf_run;
  logic [7:0]  scan_mount;
  logic        scan_mount_open;
  logic        scan_done;

  head_result_t due_results [$];
  logic [7:0]   req_bytes [$];

  int mismatches   = 0;
  int scanned_bytes = 0;
  int heads_closed = 0;
  int hold_cycles  = 0;
  int in_gap_top   = 11;
  int in_quiet     = 0;
  int out_quiet    = 0;

  function automatic int pick_gap(inout int quiet_left, input int top);
    if (quiet_left > 0) begin
      quiet_left--;
      return 0;
    end
    if ($urandom_range(0, 40) == 0) begin
      quiet_left = $urandom_range(20, 100);
      return 0;
    end
    return $urandom_range(0, top);
  endfunction

  function automatic logic is_mount_stop(input logic [7:0] c);
    return c == CHAR_SP || c == CHAR_AMP || c == CHAR_QM || c == CHAR_LF ||
           c == CHAR_CR || c == CHAR_NUL;
  endfunction

  task automatic clear_scan();
    scan_count      = '0;
    scan_cands      = '1;
    scan_last_eol   = '1;
    scan_lf_run     = '0;
    scan_mount      = '0;
    scan_mount_open = 1'b0;
    scan_done       = 1'b0;
  endtask

  // Advances the scan by one accepted byte and queues the result it closes, if any.
  task automatic scan_head_byte(input logic [7:0] b, input logic nr);
    logic [15:0]       i;
    hrhs_pkg::method_t m;
    head_result_t      r;
    if (nr) clear_scan();
    if (scan_done) return;
    scanned_bytes++;
    i = scan_count;

    if (scan_mount_open) begin
      if (is_mount_stop(b)) scan_mount_open = 1'b0;
      else if (scan_mount != hrhs_pkg::MOUNT_SAT) scan_mount++;
    end

    for (int k = 0; k < NUM_METHODS; k++)
      if (i < method_word[k].len() && 8'(method_word[k][int'(i)]) != b)
        scan_cands[k] = 1'b0;
    if (i == 16'd3 && scan_cands[CAND_PUT]) scan_mount_open = 1'b1;
    if (i == 16'd6 && scan_cands[CAND_SOURCE]) scan_mount_open = 1'b1;

    if (b == CHAR_LF || b == CHAR_CR) begin
      // CR/LF run broken by any other byte
      if (scan_last_eol != 16'(i - 16'd1)) scan_lf_run = '0;
      scan_last_eol = i;
      if (b == CHAR_LF) scan_lf_run = scan_lf_run + 2'd1;
      if (scan_lf_run == 2'd2) begin
        scan_done = 1'b1;
        r = head_result_t'{hrhs_pkg::ST_OK, hrhs_pkg::METH_NONE, i, 8'd0};
        if (i < lim_min_head) begin
          r.status = hrhs_pkg::ST_SHORT;
        end else begin
          m = hrhs_pkg::METH_NONE;
          for (int k = NUM_METHODS - 1; k >= 0; k--)
            if (scan_cands[k] && method_word[k].len() <= i) m = hrhs_pkg::method_t'(k + 1);
          if (m == hrhs_pkg::METH_NONE) begin
            r.status = hrhs_pkg::ST_UNKNOWN;
          end else begin
            r.method = m;
            if (m == hrhs_pkg::METH_PUT || m == hrhs_pkg::METH_SOURCE) begin
              r.mount_length = scan_mount;
              if (scan_mount < lim_min_mount || scan_mount > lim_max_mount ||
                  scan_mount == hrhs_pkg::MOUNT_SAT)
                r.status = hrhs_pkg::ST_BAD_MOUNT;
            end
          end
        end
        due_results.push_back(r);
        heads_closed++;
        return;
      end
    end

    if (32'(i) + 1 >= 32'(lim_max_head) || i == 16'hFFFF) begin
      scan_done = 1'b1;
      due_results.push_back(head_result_t'{hrhs_pkg::ST_OVERFLOW, hrhs_pkg::METH_NONE,
                                           16'd0, 8'd0});
      heads_closed++;
      return;
    end
    scan_count = i + 16'd1;
  endtask

  // valid is only lowered when a gap follows, so back-to-back beats keep it high
  task automatic send_byte(input logic [7:0] b, input logic nr);
    int gap;
    gap = pick_gap(in_quiet, in_gap_top);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.byte_value  <= b;
    in_ch.new_request <= nr;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    scan_head_byte(b, nr);
  endtask

  task automatic send_built(input logic first_nr);
    foreach (req_bytes[j]) send_byte(req_bytes[j], (j == 0) ? first_nr : 1'b0);
  endtask

  task automatic add_text(input string s);
    for (int j = 0; j < s.len(); j++) req_bytes.push_back(s[j]);
  endtask

  task automatic add_fill(input int n, input logic [7:0] c);
    repeat (n) req_bytes.push_back(c);
  endtask

  // "\015" is CR
  task automatic send_text(input string s);
    req_bytes.delete();
    add_text(s);
    send_built(1'b1);
  endtask

  task automatic send_mount(input string word, input int n, input logic [7:0] stop);
    req_bytes.delete();
    add_text(word);
    add_fill(n, "m");
    req_bytes.push_back(stop);
    add_text("x HTTP/1.0\015\n\015\n");
    send_built(1'b1);
  endtask

  task automatic write_reg(input hrhs_pkg::cfg_reg_t idx, input logic [15:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
  endtask

  // Upper data bits of the 8-bit registers carry junk that must be dropped.
  task automatic set_config(input logic [15:0] max_head, input logic [7:0] min_head,
                            input logic [7:0] min_mount, input logic [7:0] max_mount);
    write_reg(hrhs_pkg::REG_MAX_HEAD, max_head);
    write_reg(hrhs_pkg::REG_MIN_HEAD, {8'($urandom), min_head});
    write_reg(hrhs_pkg::REG_MIN_MOUNT, {8'($urandom), min_mount});
    write_reg(hrhs_pkg::REG_MAX_MOUNT, {8'($urandom), max_mount});
    cfg_ch.valid <= 1'b0;
    lim_max_head  = max_head;
    lim_min_head  = min_head;
    lim_min_mount = min_mount;
    lim_max_mount = max_mount;
  endtask

  // Idle point: input quiet, every result back, pipeline flushed.
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic check_result();
    head_result_t want;
    if (due_results.size() == 0) begin
      $error("result with none pending: status %0d head_length %0d",
             out_ch.status, out_ch.head_length);
      mismatches++;
      return;
    end
    want = due_results.pop_front();
    if (out_ch.status !== want.status) begin
      $error("status: expected %0d, got %0d", want.status, out_ch.status);
      mismatches++;
    end
    if (out_ch.method !== want.method) begin
      $error("method: expected %0d, got %0d", want.method, out_ch.method);
      mismatches++;
    end
    if (out_ch.head_length !== want.head_length) begin
      $error("head_length: expected %0d, got %0d", want.head_length, out_ch.head_length);
      mismatches++;
    end
    if (out_ch.mount_length !== want.mount_length) begin
      $error("mount_length: expected %0d, got %0d", want.mount_length, out_ch.mount_length);
      mismatches++;
    end
  endtask

  function automatic logic [7:0] noise_byte();
    case ($urandom_range(0, 7))
      0: return CHAR_LF;
      1: return CHAR_CR;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [7:0] mount_char();
    logic [7:0] c;
    if ($urandom_range(0, 3) != 0) return 8'("a" + $urandom_range(0, 25));
    do c = 8'($urandom_range(1, 255)); while (is_mount_stop(c));
    return c;
  endfunction

  task automatic add_eol();
    if ($urandom_range(0, 2) != 0) req_bytes.push_back(CHAR_CR);
    req_bytes.push_back(CHAR_LF);
  endtask

  // Mostly well-formed heads with random content; some noise and broken words.
  task automatic build_random_request();
    int k;
    int n;
    int pick;
    req_bytes.delete();
    pick = $urandom_range(0, 11);
    if (pick == 0) begin
      repeat ($urandom_range(1, 40)) req_bytes.push_back(noise_byte());
      return;
    end
    k = $urandom_range(0, NUM_METHODS - 1);
    if (pick == 1) begin
      n = $urandom_range(1, method_word[k].len() - 1);
      for (int j = 0; j < n; j++) req_bytes.push_back(method_word[k][j]);
      if ($urandom_range(0, 1) != 0) req_bytes[$urandom_range(0, n - 1)] = noise_byte();
    end else begin
      add_text(method_word[k]);
    end
    n = ($urandom_range(0, 19) == 0) ? $urandom_range(120, 300) : $urandom_range(0, 12);
    repeat (n) req_bytes.push_back(mount_char());
    if ($urandom_range(0, 2) != 0) req_bytes.push_back(CHAR_SP);
    else req_bytes.push_back(stop_chars[$urandom_range(0, 5)]);
    add_text("q HTTP/1.1");
    add_eol();
    repeat ($urandom_range(0, 2)) begin
      add_text("Host: h");
      repeat ($urandom_range(0, 6)) req_bytes.push_back(mount_char());
      if ($urandom_range(0, 7) == 0) req_bytes.push_back(noise_byte());
      add_eol();
    end
    case ($urandom_range(0, 7))
      0: ;
      1: repeat ($urandom_range(1, 6)) req_bytes.push_back(noise_byte());
      2: add_text("\015\015\n");
      default: add_eol();
    endcase
    if ($urandom_range(0, 4) == 0)
      repeat ($urandom_range(1, 8)) req_bytes.push_back(noise_byte());
  endtask

  task automatic test_methods();
    drain();
    set_config(16'd4096, 8'd8, 8'd5, 8'd127);
    for (int k = 0; k < NUM_METHODS; k++) begin
      req_bytes.delete();
      add_text(method_word[k]);
      add_text("/live1\n\n");
      send_built(1'b1);
    end
    send_text("FOO /abc\n\n");
    send_text("GETX /ab\n\n");
    send_text("POS /abc\n\n");
  endtask

  task automatic test_head_endings();
    drain();
    set_config(16'd4096, 8'd8, 8'd5, 8'd127);
    send_text("GET /a\n\n");
    send_text("GET /ab\n\n");
    send_text("GET /ab\n\015\n");
    send_text("GET /ab\015\015\015\n\015\015\n");
    send_text("GET /ab\nx\nHost: y\n\n");
    send_text("\n\n");
  endtask

  task automatic test_mount_limits();
    drain();
    set_config(16'd4096, 8'd8, 8'd5, 8'd6);
    send_mount("PUT ", 4, CHAR_SP);
    send_mount("PUT ", 5, CHAR_SP);
    send_mount("PUT ", 6, CHAR_SP);
    send_mount("PUT ", 7, CHAR_SP);
    send_mount("PUT ", 0, CHAR_SP);
    send_mount("SOURCE ", 5, CHAR_AMP);
    send_mount("SOURCE ", 5, CHAR_QM);
    send_mount("SOURCE ", 5, CHAR_CR);
    send_mount("SOURCE ", 5, CHAR_NUL);
    send_text("SOURCE /abc\n\n");
    drain();
    // count stops at 255, which is bad even with the widest limits
    set_config(16'd4096, 8'd8, 8'd0, 8'd255);
    send_mount("PUT ", 256, CHAR_SP);
  endtask

  task automatic test_ignore_after_result();
    drain();
    set_config(16'd4096, 8'd8, 8'd5, 8'd127);
    send_text("GET / HTTP/1.0\015\n\015\nGET /x\n\n\n\n");
    req_bytes.delete();
    add_text("POST /x\n\n");
    send_built(1'b0);
    // restart in the middle of an open head
    send_text("GET /abc");
    send_text("HEAD / HTTP/1.0\n\n");
  endtask

  task automatic test_overflow();
    drain();
    set_config(16'd16, 8'd0, 8'd0, 8'd255);
    send_text("GET /aaaaaaaaaaaaaaaaaaaa\n\n");
    send_text("GET /abcdefghi\n\n");
    send_text("HEA\n\n");
    send_text("\015\n\015\n");
    send_text("GET \n\n");
  endtask

  task automatic test_config_extremes();
    drain();
    set_config(16'hFFFF, 8'hFF, 8'hFF, 8'hFF);
    send_text("GET / HTTP/1.0\015\n\015\n");
    drain();
    set_config(16'd16, 8'hFF, 8'd0, 8'd0);
    send_text("GET /\n\n");
    send_text("GET /aaaaaaaaaaaaaaa");
    drain();
    set_config(16'hFFFF, 8'd0, 8'd0, 8'd0);
    send_text("PUT  x\n\n");
    send_text("PUT /a\n\n");
    send_text("\n\n");
  endtask

  task automatic test_backpressure();
    drain();
    set_config(16'd4096, 8'd8, 8'd5, 8'd127);
    in_gap_top  = 0;
    hold_cycles = 300;
    repeat (20) send_text("\n\n");
    in_gap_top = 11;
  endtask

  task automatic test_random();
    int   bytes_goal;
    int   heads_goal;
    logic first_nr;
    for (int p = 0; p < 5; p++) begin
      drain();
      case (p)
        0: set_config(16'd4096, 8'd8, 8'd5, 8'd127);
        1: set_config(16'($urandom_range(16, 90)), 8'($urandom_range(0, 30)),
                      8'($urandom_range(0, 6)), 8'($urandom_range(0, 20)));
        2: set_config(16'hFFFF, 8'd0, 8'd0, 8'hFF);
        3: set_config(16'($urandom_range(16, 65535)), 8'($urandom_range(0, 255)),
                      8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        default: set_config(16'($urandom_range(100, 600)), 8'($urandom_range(0, 12)),
                            8'($urandom_range(1, 8)), 8'($urandom_range(6, 40)));
      endcase
      bytes_goal = scanned_bytes + 40;
      heads_goal = heads_closed + 2;
      while (scanned_bytes < bytes_goal || heads_closed < heads_goal) begin
        build_random_request();
        first_nr = ($urandom_range(0, 9) != 0);
        foreach (req_bytes[j])
          send_byte(req_bytes[j], (j == 0) ? first_nr : ($urandom_range(0, 149) == 0));
      end
    end
  endtask

  initial begin : result_sink
    int wait_cycles;
    out_ch.ready <= 1'b0;
    do @(posedge clk); while (rst_n !== 1'b1);
    forever begin
      if (hold_cycles > 0) begin
        wait_cycles = hold_cycles;
        hold_cycles = 0;
      end else begin
        wait_cycles = pick_gap(out_quiet, 11);
      end
      if (wait_cycles > 0) begin
        out_ch.ready <= 1'b0;
        repeat (wait_cycles) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (out_ch.valid !== 1'b1 && hold_cycles == 0);
      if (out_ch.valid === 1'b1) check_result();
    end
  end

  initial begin
    #10_000_000;
    $display("tb_top failed");
    $finish;
  end

  initial begin
    in_ch.valid       <= 1'b0;
    in_ch.byte_value  <= 8'd0;
    in_ch.new_request <= 1'b0;
    cfg_ch.valid      <= 1'b0;
    cfg_ch.index      <= hrhs_pkg::REG_MAX_HEAD;
    cfg_ch.data       <= 16'd0;
    rst_n             <= 1'b0;
    lim_max_head  = 16'd4096;
    lim_min_head  = 8'd8;
    lim_min_mount = 8'd5;
    lim_max_mount = 8'd127;
    clear_scan();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_methods();
    test_head_endings();
    test_mount_limits();
    test_ignore_after_result();
    test_overflow();
    test_config_extremes();
    test_backpressure();
    test_random();

    drain();
    if (mismatches == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
